### rtl/core/sblru_pkg.sv
// package for the size budget lru cache: payload structs, codes, constants
// no dependencies
`timescale 1ns / 1ps
package sblru_pkg;
   localparam int DefEntries = 32;
   localparam logic [31:0] BudgetReset = 32'd4194304;
   localparam logic [3:0] BppReset = 4'd2;
   localparam int CsrIdxW = 1;
   localparam logic [CsrIdxW-1:0] CsrBudget = 1'b0;
   localparam logic [CsrIdxW-1:0] CsrBpp = 1'b1;

   typedef enum logic [1:0] {
      KIND_HIT = 2'd0, KIND_EVICT = 2'd1, KIND_LOAD = 2'd2, KIND_REJECT = 2'd3
   } kind_type;

   typedef struct packed {
      logic        op;
      logic [15:0] item_id;
      logic [23:0] pixel_count;
      logic        reload;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] item_id_out;
      logic [31:0] item_bytes;
      logic [31:0] used_bytes;
      logic [5:0]  entry_count;
      logic        last;
   } rsp_type;

   // classified transaction handed from front to back
   typedef struct packed {
      logic        op;
      logic [15:0] item_id;
      logic [31:0] bytes;
      logic        reload;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOOK, ST_DECIDE, ST_EVICT, ST_LOAD, ST_EMIT
   } state_type;
endpackage

### rtl/core/sblru_front.sv
// front: accepts requests, computes byte size, buffers up to two jobs in a short queue
// depends on sblru_pkg
`timescale 1ns / 1ps
module sblru_front (
   input  logic                clock,
   input  logic                reset,
   input  logic [3:0]          bpp,
   input  logic                req_valid,
   output logic                req_stall,
   input  sblru_pkg::req_type  req_data,
   output logic                job_valid,
   input  logic                job_take,
   output sblru_pkg::job_type  job_data
);
   import sblru_pkg::*;
   job_type q_ff [2];
   job_type job_in;
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic push, pop;

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop = job_valid && job_take;
   assign job_data = q_ff[rd_ff];

   // size computation and queue pointer next values
   always_comb begin
      job_in.op = req_data.op;
      job_in.item_id = req_data.item_id;
      job_in.bytes = 32'({4'd0, req_data.pixel_count} * {24'd0, bpp});
      job_in.reload = req_data.reload;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in = rd_ff ^ pop;
      wr_in = wr_ff ^ push;
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= job_in;
   end
endmodule

### rtl/core/sblru_back.sv
// back: slot table, lookup, eviction and rank update, result register
// depends on sblru_pkg
`timescale 1ns / 1ps
module sblru_back #(
   parameter int ENTRIES = sblru_pkg::DefEntries
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [31:0]         budget,
   input  logic                job_valid,
   output logic                job_take,
   input  sblru_pkg::job_type  job_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sblru_pkg::rsp_type  rsp_data
);
   import sblru_pkg::*;
   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   logic [15:0] id_ff [ENTRIES];
   logic [31:0] by_ff [ENTRIES];
   logic [IW-1:0] rk_ff [ENTRIES];
   logic [ENTRIES-1:0] val_ff;
   logic [31:0] used_ff, used_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   state_type st_ff, st_in;
   job_type job_ff;
   logic [ENTRIES-1:0] hitv_ff, rkv_ff;
   logic hit_c;
   logic [IW-1:0] fidx_ff;
   rsp_type rsp_ff, rsp_in;
   logic rv_ff;
   logic emit_ev, emit_fin;
   logic [1:0] fkind;
   logic [IW-1:0] want_rank;
   logic [IW-1:0] tidx_c, fidx_c, hidx_c;
   logic do_evict, ev_last;

   assign rsp_valid = rv_ff;
   assign rsp_data = rsp_ff;
   assign job_take = (st_ff == ST_IDLE) && !rv_ff;
   assign hit_c = |hitv_ff;

   // rank to look for during eviction
   assign want_rank = job_ff.op ? '0 : IW'(cnt_ff - 1'b1);

   // encoders over registered match vectors and valid bits
   always_comb begin
      tidx_c = '0;
      hidx_c = '0;
      fidx_c = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (rkv_ff[i]) tidx_c = IW'(i);
         if (hitv_ff[i]) hidx_c = IW'(i);
         if (!val_ff[i]) fidx_c = IW'(i);
      end
   end

   // eviction needed
   always_comb begin
      if (job_ff.op) do_evict = (cnt_ff != '0);
      else do_evict = (cnt_ff != '0) &&
         (({1'b0, used_ff} + {1'b0, job_ff.bytes} >= {1'b0, budget}) ||
          (cnt_ff >= CW'(ENTRIES)));
      ev_last = job_ff.op && (cnt_ff == CW'(1));
   end

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (job_valid && job_take) st_in = ST_LOOK;
         ST_LOOK: st_in = ST_DECIDE;
         ST_DECIDE: begin
            if (rv_ff) st_in = ST_DECIDE;
            else if (job_ff.op) st_in = (cnt_ff == '0) ? ST_IDLE : ST_EVICT;
            else if (hit_c && job_ff.reload) st_in = ST_LOOK;
            else if (hit_c) st_in = ST_IDLE;
            else if (job_ff.bytes >= budget) st_in = ST_IDLE;
            else if (do_evict) st_in = ST_EVICT;
            else st_in = ST_LOAD;
         end
         ST_EVICT: if (!rv_ff) st_in = ST_LOOK;
         ST_LOAD: if (!rv_ff) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // result outputs
   always_comb begin
      emit_ev = 1'b0;
      emit_fin = 1'b0;
      fkind = KIND_HIT;
      rsp_in = rsp_ff;
      used_in = used_ff;
      cnt_in = cnt_ff;
      case (st_ff)
         ST_DECIDE: begin
            if (!rv_ff && !job_ff.op) begin
               if (hit_c && job_ff.reload) emit_ev = 1'b1;
               else if (hit_c) begin
                  emit_fin = 1'b1;
                  fkind = KIND_HIT;
               end else if (job_ff.bytes >= budget) begin
                  emit_fin = 1'b1;
                  fkind = KIND_REJECT;
               end
            end
         end
         ST_EVICT: if (!rv_ff) emit_ev = 1'b1;
         ST_LOAD: if (!rv_ff) begin
            emit_fin = 1'b1;
            fkind = KIND_LOAD;
         end
         default: ;
      endcase
      if (emit_ev) begin
         used_in = used_ff - by_ff[(st_ff == ST_EVICT) ? tidx_c : hidx_c];
         cnt_in = cnt_ff - 1'b1;
         rsp_in.kind = KIND_EVICT;
         rsp_in.item_id_out = id_ff[(st_ff == ST_EVICT) ? tidx_c : hidx_c];
         rsp_in.item_bytes = by_ff[(st_ff == ST_EVICT) ? tidx_c : hidx_c];
         rsp_in.last = ev_last && (st_ff == ST_EVICT);
      end
      if (emit_fin) begin
         if (fkind == KIND_LOAD) begin
            used_in = used_ff + job_ff.bytes;
            cnt_in = cnt_ff + 1'b1;
         end
         rsp_in.kind = fkind;
         rsp_in.item_id_out = job_ff.item_id;
         rsp_in.item_bytes = (fkind == KIND_HIT) ? by_ff[hidx_c] : job_ff.bytes;
         rsp_in.last = 1'b1;
      end
      rsp_in.used_bytes = used_in;
      rsp_in.entry_count = 6'(cnt_in);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         rv_ff <= 1'b0;
         val_ff <= '0;
         used_ff <= '0;
         cnt_ff <= '0;
      end else begin
         st_ff <= st_in;
         used_ff <= used_in;
         cnt_ff <= cnt_in;
         if (emit_ev || emit_fin) rv_ff <= 1'b1;
         else if (!rsp_stall) rv_ff <= 1'b0;
         if (emit_ev) val_ff[(st_ff == ST_EVICT) ? tidx_c : hidx_c] <= 1'b0;
         if (emit_fin && fkind == KIND_LOAD) val_ff[fidx_ff] <= 1'b1;
      end
   end

   // payload, match vectors and rank update
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (job_valid && job_take) job_ff <= job_data;
      if (st_ff == ST_LOOK) begin
         for (int i = 0; i < ENTRIES; i++) begin
            hitv_ff[i] <= val_ff[i] && (id_ff[i] == job_ff.item_id);
            rkv_ff[i] <= val_ff[i] && (rk_ff[i] == want_rank);
         end
      end
      if (st_ff == ST_DECIDE) fidx_ff <= fidx_c;
      if (emit_ev) begin
         for (int i = 0; i < ENTRIES; i++)
            if (val_ff[i] &&
                rk_ff[i] > rk_ff[(st_ff == ST_EVICT) ? tidx_c : hidx_c])
               rk_ff[i] <= rk_ff[i] - 1'b1;
      end
      if (emit_fin && fkind == KIND_HIT) begin
         for (int i = 0; i < ENTRIES; i++)
            if (val_ff[i] && rk_ff[i] < rk_ff[hidx_c]) rk_ff[i] <= rk_ff[i] + 1'b1;
         rk_ff[hidx_c] <= '0;
      end
      if (emit_fin && fkind == KIND_LOAD) begin
         for (int i = 0; i < ENTRIES; i++)
            if (val_ff[i]) rk_ff[i] <= rk_ff[i] + 1'b1;
         rk_ff[fidx_ff] <= '0;
         id_ff[fidx_ff] <= job_ff.item_id;
         by_ff[fidx_ff] <= job_ff.bytes;
      end
   end
endmodule

### rtl/core/size_budget_lru_cache.sv
// top level of the size budget lru cache: registers, front and back
// depends on sblru_pkg, sblru_front, sblru_back
// usage:
//   req_ channel carries op, item_id, pixel_count, reload (valid/stall)
//   rsp_ channel returns one transaction per event: hit, evict, load,
//   reject; last marks the final result of a request
//   csr_ port writes budget_bytes (index 0) and bytes_per_pixel (index 1)
// flow:
//   a hit passes through the queue, match compare, decide and emit
//   each eviction adds a rank match compare, decide and emit;
//   a clear repeats these for each resident entry
//   the slot match vectors are rebuilt once per event, which sets the rate
//   a two-entry queue lets requests arrive while the back works
// reset:
//   synchronous; cache empty, budget 4194304, bytes_per_pixel 2
// stall:
//   while rsp_stall is high the result register holds and the back waits
`timescale 1ns / 1ps
module size_budget_lru_cache #(
   parameter int ENTRIES = sblru_pkg::DefEntries
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [sblru_pkg::CsrIdxW-1:0] csr_index,
   input  logic [31:0]         csr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  sblru_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sblru_pkg::rsp_type  rsp_data
);
   import sblru_pkg::*;
   logic [31:0] budget_ff;
   logic [3:0] bpp_ff;
   logic job_valid, job_take;
   job_type job_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BudgetReset;
         bpp_ff <= BppReset;
      end else if (csr_write) begin
         case (csr_index)
            CsrBudget: budget_ff <= csr_data;
            CsrBpp: bpp_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   sblru_front u_front (
      .clock, .reset, .bpp(bpp_ff), .req_valid, .req_stall, .req_data,
      .job_valid, .job_take, .job_data
   );

   sblru_back #(.ENTRIES(ENTRIES)) u_back (
      .clock, .reset, .budget(budget_ff), .job_valid, .job_take, .job_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule

### tb/size_budget_lru_cache_test.sv
// testbench for the size budget lru cache: directed and random accesses and clears
// predicts every result with a behavioral cache model; depends on sblru_pkg
`timescale 1ns / 1ps
module size_budget_lru_cache_test;
   import sblru_pkg::*;

   localparam int Slots = DefEntries;
   localparam int LimitCycles = 2000000;
   localparam int HoldLen = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;

   size_budget_lru_cache u_top (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // cache shadow state, ordered most recent first
   logic [31:0] budget_now;
   logic [3:0] bpp_now;
   logic [15:0] lru_id[$];
   logic [31:0] lru_bytes[$];
   logic [31:0] used_now;
   rsp_type expected_rsp[$];
   int mismatches = 0;
   int cycles = 0;
   bit hold_off = 1'b0;
   int hold_cycles = 0;
   int rsp_wait = 0;

   // append one expected result
   function automatic void note(kind_type k, logic [15:0] id, logic [31:0] b);
      rsp_type r;
      r.kind = k;
      r.item_id_out = id;
      r.item_bytes = b;
      r.used_bytes = used_now;
      r.entry_count = 6'(lru_id.size());
      r.last = 1'b0;
      expected_rsp.push_back(r);
   endfunction

   function automatic void drop_at(int p);
      logic [15:0] id;
      logic [31:0] b;
      id = lru_id[p];
      b = lru_bytes[p];
      lru_id.delete(p);
      lru_bytes.delete(p);
      used_now -= b;
      note(KIND_EVICT, id, b);
   endfunction

   // expected results of one request
   function automatic void predict_access(req_type q);
      int before_n;
      int pos;
      logic [31:0] sz;
      logic [15:0] hid;
      logic [31:0] hb;
      before_n = expected_rsp.size();
      pos = -1;
      sz = 32'(q.pixel_count) * 32'(bpp_now);
      if (q.op) begin
         while (lru_id.size() > 0) drop_at(0);
      end else begin
         foreach (lru_id[i]) if (pos < 0 && lru_id[i] == q.item_id) pos = i;
         if (pos >= 0 && q.reload) begin
            drop_at(pos);
            pos = -1;
         end
         if (pos >= 0) begin
            hid = lru_id[pos];
            hb = lru_bytes[pos];
            lru_id.delete(pos);
            lru_bytes.delete(pos);
            lru_id.push_front(hid);
            lru_bytes.push_front(hb);
            note(KIND_HIT, hid, hb);
         end else if (sz >= budget_now) begin
            note(KIND_REJECT, q.item_id, sz);
         end else begin
            while (lru_id.size() > 0 &&
                   ({32'd0, used_now} + {32'd0, sz} >= {32'd0, budget_now} ||
                    lru_id.size() >= Slots))
               drop_at(lru_id.size() - 1);
            lru_id.push_front(q.item_id);
            lru_bytes.push_front(sz);
            used_now += sz;
            note(KIND_LOAD, q.item_id, sz);
         end
      end
      if (expected_rsp.size() > before_n)
         expected_rsp[expected_rsp.size() - 1].last = 1'b1;
   endfunction

   // send one request transaction after a random gap
   task automatic send_request(req_type q);
      int gap;
      gap = $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= q;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_access(q);
      @(negedge clock);
   endtask

   task automatic access(logic [15:0] id, logic [23:0] pix, logic rel);
      req_type q;
      q.op = 1'b0;
      q.item_id = id;
      q.pixel_count = pix;
      q.reload = rel;
      send_request(q);
   endtask

   task automatic clear_all();
      req_type q;
      q = '0;
      q.op = 1'b1;
      q.item_id = 16'($urandom);
      q.pixel_count = 24'($urandom);
      q.reload = 1'($urandom);
      send_request(q);
   endtask

   // wait for the block to drain, then write a register
   task automatic write_reg(logic [CsrIdxW-1:0] idx, logic [31:0] val);
      req_valid <= 1'b0;
      while (expected_rsp.size() > 0) @(negedge clock);
      repeat (120) @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CsrBudget) budget_now = val;
      else bpp_now = val[3:0];
   endtask

   // response receiver: per-transaction wait or the long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (hold_off && hold_cycles < HoldLen) || (rsp_wait > 0);
      end
   end

   // hold-off length counted in cycles
   always @(negedge clock) begin
      if (hold_off && hold_cycles < HoldLen) hold_cycles <= hold_cycles + 1;
   end

   // compare each response transaction with the oldest expectation
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_wait <= $urandom_range(0, 15);
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            if (rsp_data !== expected_rsp[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p actual %p", expected_rsp[0], rsp_data);
            end
            void'(expected_rsp.pop_front());
         end
      end else if (rsp_wait > 0) begin
         rsp_wait <= rsp_wait - 1;
      end
   end

   // timeout
   always @(posedge clock) begin
      if (cycles >= LimitCycles) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic test_directed();
      access(16'h0001, 24'd100, 1'b0);
      access(16'h0001, 24'd5, 1'b0);
      access(16'hFFFF, 24'hFFFFFF, 1'b0);
      access(16'h0000, 24'd0, 1'b0);
      access(16'h0002, 24'd1000, 1'b0);
      access(16'h0001, 24'd300, 1'b1);
      access(16'h0077, 24'd50, 1'b1);
      access(16'h0002, 24'd0, 1'b0);
      clear_all();
      clear_all();
   endtask

   task automatic test_budget_edges();
      write_reg(CsrBudget, 32'd1000);
      write_reg(CsrBpp, 32'd1);
      access(16'h0010, 24'd999, 1'b0);
      access(16'h0011, 24'd1000, 1'b0);
      access(16'h0012, 24'd400, 1'b0);
      access(16'h0013, 24'd400, 1'b0);
      access(16'h0010, 24'd999, 1'b1);
      access(16'h0014, 24'd1500, 1'b1);
      write_reg(CsrBudget, 32'd0);
      access(16'h0015, 24'd0, 1'b0);
      write_reg(CsrBudget, 32'hFFFFFFFF);
      write_reg(CsrBpp, 32'd15);
      access(16'h0016, 24'hFFFFFF, 1'b0);
      write_reg(CsrBpp, 32'd0);
      access(16'h0017, 24'hABCDEF, 1'b0);
      clear_all();
   endtask

   // more than the slot count of small items forces slot eviction
   task automatic test_slots_full();
      write_reg(CsrBudget, 32'hFFFFFFFF);
      write_reg(CsrBpp, 32'd8);
      for (int i = 0; i < Slots + 3; i++) access(16'(16'h0100 + i), 24'd10, 1'b0);
      access(16'h0103, 24'd10, 1'b0);
      clear_all();
   endtask

   task automatic random_phase(int n, int id_span, int pix_max);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 3) clear_all();
         else if (r < 6)
            access(16'($urandom), 24'($urandom), 1'($urandom));
         else
            access(16'($urandom_range(0, id_span)), 24'($urandom_range(0, pix_max)),
                   ($urandom_range(0, 9) == 0));
      end
   endtask

   task automatic test_random();
      write_reg(CsrBudget, 32'd4194304);
      write_reg(CsrBpp, 32'd2);
      random_phase(110, 40, 400000);
      write_reg(CsrBudget, 32'd5000);
      write_reg(CsrBpp, 32'd4);
      random_phase(110, 20, 600);
      write_reg(CsrBudget, 32'hFFFFFFFF);
      write_reg(CsrBpp, 32'd1);
      random_phase(110, 60, 1000);
      write_reg(CsrBudget, 32'($urandom_range(100, 100000)));
      write_reg(CsrBpp, 32'($urandom_range(1, 8)));
      random_phase(110, 30, 5000);
   endtask

   // receiver holds off while requests pile up
   task automatic test_backpressure();
      hold_off = 1'b1;
      for (int i = 0; i < 12; i++) access(16'(16'h0200 + i % 5), 24'd20, 1'b0);
   endtask

   initial begin
      budget_now = BudgetReset;
      bpp_now = BppReset;
      used_now = 32'd0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_budget_edges();
      test_slots_full();
      test_random();
      test_backpressure();
      req_valid <= 1'b0;
      while (expected_rsp.size() > 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
